/* rtl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared widths and codes for the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int FRAME_W       = 12;
  localparam int FRAME_COUNT_W = 13;
  localparam int STATUS_W      = 2;

  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_DONE    = 2'd0;
  localparam status_t STATUS_NOTHING = 2'd1;
  localparam status_t STATUS_NO_FREE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

/* rtl/fba_ram.sv */
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/frame_bitmap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_unit
// First-fit page frame allocator over a bitmap kept in a single-port RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | opcode, current_frame, kernel_page,
//           |                       | writable_page
//  out      | out_valid / out_ready | frame_number, present_flag,
//           |                       | writable_flag, user_flag, status
//  cfg      | cfg_wr_en             | cfg_wr_data (frame_count)
//
// after reset a clearing pass writes every bitmap word to zero, one word per
// cycle (MAX_FRAMES / WORD_BITS words, 128 by default); in_ready stays low
// allocation reads one bitmap word per cycle through the RAM port until a
// free frame is found or the scan limit is reached; free runs a reciprocal
// multiply, a read and a write; trivial requests go straight to the result
// one request at a time; a result waiting on out_ready holds the unit
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit
  import fba_pkg::*;
#(
  parameter int MAX_FRAMES = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     opcode,
  input  logic [FRAME_W-1:0]       current_frame,
  input  logic                     kernel_page,
  input  logic                     writable_page,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRAME_W-1:0]       frame_number,
  output logic                     present_flag,
  output logic                     writable_flag,
  output logic                     user_flag,
  output status_t                  status,

  input  logic                     cfg_wr_en,
  input  logic [FRAME_COUNT_W-1:0] cfg_wr_data
);

  localparam int DEPTH    = MAX_FRAMES / WORD_BITS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCNT_W   = $clog2(DEPTH + 1);
  localparam int BIT_W    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int BASE_W   = $clog2(MAX_FRAMES + WORD_BITS + 1);
  localparam int CMP_W    = ((BASE_W > FRAME_COUNT_W) ? BASE_W : FRAME_COUNT_W) + 1;
  // quotient by reciprocal: exact for 12-bit frames and divisors up to 64
  localparam int RECIP_SH = 20;
  localparam int RECIP    = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = FRAME_W + RECIP_W;
  localparam int WB_W     = $clog2(WORD_BITS + 1);
  localparam int QMUL_W   = FRAME_W + WB_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FDIV  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FWR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]               state;
  logic [2:0]               state_next;

  logic [FRAME_COUNT_W-1:0] frame_count;

  logic [FRAME_W-1:0]       req_frame;
  logic                     req_kernel;
  logic                     req_write;

  logic [ADDR_W-1:0]        clr_addr;
  logic [WCNT_W-1:0]        rd_w;
  logic [BASE_W-1:0]        rd_base;
  logic                     chk_valid;
  logic [ADDR_W-1:0]        chk_w;
  logic [BASE_W-1:0]        chk_base;

  logic [FRAME_W-1:0]       quot;
  logic [BIT_W-1:0]         free_off;
  logic [ADDR_W-1:0]        free_addr;
  logic                     free_hit;

  logic [FRAME_W-1:0]       res_frame;
  logic                     res_present;
  logic                     res_write;
  logic                     res_user;
  status_t                  res_status;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_addr;
  logic [WORD_BITS-1:0]     ram_wdata;
  logic [WORD_BITS-1:0]     ram_rdata;

  logic                     accept;
  logic                     can_issue;
  logic                     found;
  logic [WORD_BITS-1:0]     free_onehot;
  logic [BIT_W-1:0]         bit_idx;
  logic [PROD_W-1:0]        quot_prod;
  logic [QMUL_W-1:0]        quot_back;
  logic [QMUL_W-1:0]        rem_full;
  logic                     quot_in_range;
  logic [BASE_W-1:0]        found_frame;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // scan word w only while (w + 1) * WORD_BITS <= frame_count
  assign can_issue = (CMP_W'(rd_base) + CMP_W'(WORD_BITS) <= CMP_W'(frame_count)) &&
                     (rd_w < WCNT_W'(DEPTH));
  assign found     = chk_valid && !(&ram_rdata);

  // lowest clear bit as a one-hot
  assign free_onehot = ~ram_rdata & (ram_rdata + WORD_BITS'(1));

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (free_onehot[i]) begin
        bit_idx = bit_idx | BIT_W'(i);
      end
    end
  end

  assign found_frame = chk_base + BASE_W'(bit_idx);

  assign quot_prod     = PROD_W'(req_frame) * PROD_W'(RECIP);
  assign quot_back     = QMUL_W'(quot) * QMUL_W'(WORD_BITS);
  assign rem_full      = QMUL_W'(req_frame) - quot_back;
  assign quot_in_range = (32'(quot) < 32'(DEPTH));

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rd_w[ADDR_W-1:0];
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_SCAN: begin
        if (found) begin
          ram_we    = 1'b1;
          ram_addr  = chk_w;
          ram_wdata = ram_rdata | free_onehot;
        end
      end
      S_FRD: begin
        ram_addr = ADDR_W'(quot);
      end
      S_FWR: begin
        ram_we    = free_hit;
        ram_addr  = free_addr;
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << free_off);
      end
      S_IDLE, S_FDIV, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (current_frame != '0) begin
            state_next = (opcode == OP_ALLOC) ? S_DONE : S_FDIV;
          end else begin
            state_next = (opcode == OP_ALLOC) ? S_SCAN : S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (found || (!can_issue && !chk_valid)) begin
          state_next = S_DONE;
        end
      end
      S_FDIV: state_next = S_FRD;
      S_FRD: begin
        state_next = quot_in_range ? S_FWR : S_DONE;
      end
      S_FWR: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      chk_valid   <= 1'b0;
      frame_count <= FRAME_COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        frame_count <= cfg_wr_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == S_IDLE) begin
        chk_valid <= 1'b0;
      end else if (state == S_SCAN) begin
        chk_valid <= !found && can_issue;
      end
    end
  end

  // request data, scan pointers and results
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req_frame  <= current_frame;
        req_kernel <= kernel_page;
        req_write  <= writable_page;
        rd_w       <= '0;
        rd_base    <= '0;
        res_frame   <= '0;
        res_present <= 1'b0;
        res_write   <= 1'b0;
        res_user    <= 1'b0;
        if (opcode == OP_ALLOC && current_frame != '0) begin
          res_frame  <= current_frame;
          res_status <= STATUS_NOTHING;
        end else if (opcode == OP_FREE && current_frame == '0) begin
          res_status <= STATUS_NOTHING;
        end else begin
          res_status <= STATUS_DONE;
        end
      end
      S_SCAN: begin
        if (found) begin
          res_frame   <= found_frame[FRAME_W-1:0];
          res_present <= 1'b1;
          res_write   <= req_write;
          res_user    <= ~req_kernel;
          res_status  <= STATUS_DONE;
        end else if (can_issue) begin
          chk_w    <= rd_w[ADDR_W-1:0];
          chk_base <= rd_base;
          rd_w     <= rd_w + WCNT_W'(1);
          rd_base  <= rd_base + BASE_W'(WORD_BITS);
        end else if (!chk_valid) begin
          res_status <= STATUS_NO_FREE;
        end
      end
      S_FDIV: begin
        quot <= quot_prod[RECIP_SH +: FRAME_W];
      end
      S_FRD: begin
        free_off  <= rem_full[BIT_W-1:0];
        free_addr <= ADDR_W'(quot);
        free_hit  <= quot_in_range;
      end
      S_CLEAR, S_FWR, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      frame_number  <= res_frame;
      present_flag  <= res_present;
      writable_flag <= res_write;
      user_flag     <= res_user;
      status        <= res_status;
    end
  end

  fba_ram #(
    .WIDTH  (WORD_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

/* bench/frame_bitmap_allocator_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_unit_tb
// Self-checking bench for the first-fit frame allocator. Requests are driven
// through the valid/ready input channel with random gaps, results are taken
// with random stalls and compared field by field against an in-bench bitmap
// model. Covers directed corner cases, small pools run to exhaustion, mixed
// random traffic under several frame counts and a larger pool fill.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit_tb
  import fba_pkg::*;
();

  localparam int MAP_WORD  = 32;
  localparam int MAP_DEPTH = 128;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user;
    status_t            status;
  } frame_grant_t;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic                     opcode        = OP_ALLOC;
  logic [FRAME_W-1:0]       current_frame = '0;
  logic                     kernel_page   = 1'b0;
  logic                     writable_page = 1'b0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic [FRAME_W-1:0]       frame_number;
  logic                     present_flag;
  logic                     writable_flag;
  logic                     user_flag;
  status_t                  status;
  logic                     cfg_wr_en     = 1'b0;
  logic [FRAME_COUNT_W-1:0] cfg_wr_data   = '0;

  // bench copy of the allocator state
  logic [MAP_WORD-1:0]      frame_map [MAP_DEPTH];
  logic [FRAME_COUNT_W-1:0] pool_count = FRAME_COUNT_RESET;
  logic [FRAME_W-1:0]       held_frames [$];
  frame_grant_t             pending_grants [$];

  int fail_count  = 0;
  bit idle_enable = 1'b1;
  int ready_stall = 0;

  frame_bitmap_allocator_unit #(
    .MAX_FRAMES(4096),
    .WORD_BITS (MAP_WORD)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .current_frame(current_frame),
    .kernel_page  (kernel_page),
    .writable_page(writable_page),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_number (frame_number),
    .present_flag (present_flag),
    .writable_flag(writable_flag),
    .user_flag    (user_flag),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(50_000_000);
    $display("** frame_bitmap_allocator_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic int scan_words();
    int words;
    words = pool_count / MAP_WORD;
    if (words > MAP_DEPTH) words = MAP_DEPTH;
    return words;
  endfunction

  function automatic frame_grant_t compute_grant(logic op, logic [FRAME_W-1:0] cur,
                                                 logic kern, logic wr);
    frame_grant_t g;
    int words, w, b;
    g = '0;
    if (op == OP_ALLOC) begin
      if (cur != '0) begin
        g.frame  = cur;
        g.status = STATUS_NOTHING;
      end else begin
        words    = scan_words();
        g.status = STATUS_NO_FREE;
        for (w = 0; w < words && g.status == STATUS_NO_FREE; w++) begin
          if (frame_map[w] != '1) begin
            for (b = 0; b < MAP_WORD && g.status == STATUS_NO_FREE; b++) begin
              if (!frame_map[w][b]) begin
                frame_map[w][b] = 1'b1;
                g.frame    = FRAME_W'(w * MAP_WORD + b);
                g.present  = 1'b1;
                g.writable = wr;
                g.user     = ~kern;
                g.status   = STATUS_DONE;
                held_frames.push_back(g.frame);
              end
            end
          end
        end
      end
    end else if (cur == '0) begin
      g.status = STATUS_NOTHING;
    end else begin
      // cleared by index, never checked against the frame count
      frame_map[cur / MAP_WORD][cur % MAP_WORD] = 1'b0;
      g.status = STATUS_DONE;
    end
    return g;
  endfunction

  function automatic int free_frames_in_scan();
    int w, n;
    n = 0;
    for (w = 0; w < scan_words(); w++) n += MAP_WORD - $countones(frame_map[w]);
    return n;
  endfunction

  function automatic void collect_held_frames();
    int w, b;
    held_frames.delete();
    for (w = 0; w < MAP_DEPTH; w++)
      for (b = 0; b < MAP_WORD; b++)
        if (frame_map[w][b]) held_frames.push_back(FRAME_W'(w * MAP_WORD + b));
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------- result side

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : grant_check
    frame_grant_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result: frame_number %0d, status %0d", frame_number, status);
        fail_count++;
      end else begin
        want = pending_grants.pop_front();
        check_field("frame_number",  32'(want.frame),    32'(frame_number));
        check_field("present_flag",  32'(want.present),  32'(present_flag));
        check_field("writable_flag", 32'(want.writable), 32'(writable_flag));
        check_field("user_flag",     32'(want.user),     32'(user_flag));
        check_field("status",        32'(want.status),   32'(status));
      end
    end
    if (ready_stall != 0) begin
      out_ready   <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      out_ready   <= 1'b1;
      ready_stall <= pick_gap();
    end
  end

  // ---------------------------------------------------------------- request side

  task automatic send_request(input logic op, input logic [FRAME_W-1:0] cur,
                              input logic kern, input logic wr);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    current_frame <= cur;
    kernel_page   <= kern;
    writable_page <= wr;
    do @(posedge clk); while (!in_ready);
    pending_grants.push_back(compute_grant(op, cur, kern, wr));
  endtask

  task automatic alloc_fresh();
    send_request(OP_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic free_held_frame();
    int idx;
    logic [FRAME_W-1:0] f;
    if (held_frames.size() == 0) begin
      f = FRAME_W'($urandom_range(0, 4095));
    end else begin
      idx = $urandom_range(0, held_frames.size() - 1);
      f   = held_frames[idx];
      held_frames.delete(idx);
    end
    send_request(OP_FREE, f, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1))
      send_request(OP_ALLOC, FRAME_W'($urandom_range(1, 4095)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else
      send_request(OP_FREE, FRAME_W'($urandom_range(0, 4095)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    // every request gives a result, so waiting on the queue drains the unit
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame_count(input logic [FRAME_COUNT_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pool_count = value;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_alloc_basics();
    // first grant after reset is frame zero
    send_request(OP_ALLOC, '0, 1'b0, 1'b1);
    send_request(OP_ALLOC, '0, 1'b1, 1'b0);
    send_request(OP_ALLOC, '0, 1'b0, 1'b0);
    send_request(OP_ALLOC, '0, 1'b1, 1'b1);
    // entry already mapped
    send_request(OP_ALLOC, 12'hfff, 1'b1, 1'b1);
    send_request(OP_ALLOC, 12'h555, 1'b0, 1'b1);
    send_request(OP_ALLOC, 12'haaa, 1'b1, 1'b0);
  endtask

  task automatic test_free_cases();
    send_request(OP_FREE, '0, 1'b1, 1'b1);
    send_request(OP_FREE, 12'd2, 1'b0, 1'b0);
    send_request(OP_ALLOC, '0, 1'b0, 1'b1);
    // freeing a clear bit is harmless
    send_request(OP_FREE, 12'hfff, 1'b1, 1'b0);
    send_request(OP_FREE, 12'd1, 1'b0, 1'b1);
    send_request(OP_FREE, 12'd3, 1'b1, 1'b1);
    send_request(OP_ALLOC, '0, 1'b1, 1'b0);
    send_request(OP_ALLOC, '0, 1'b0, 1'b0);
  endtask

  task automatic test_frame_count_limits();
    set_frame_count('0);
    send_request(OP_ALLOC, '0, 1'b0, 1'b1);
    send_request(OP_FREE, 12'd1, 1'b0, 1'b0);
    send_request(OP_ALLOC, 12'd7, 1'b0, 1'b0);
    set_frame_count(13'd31);
    send_request(OP_ALLOC, '0, 1'b1, 1'b1);
    // oversized count: the scan stops at the bitmap depth
    set_frame_count(13'h1fff);
    send_request(OP_ALLOC, '0, 1'b1, 1'b0);
    set_frame_count(13'd32);
    send_request(OP_ALLOC, '0, 1'b0, 1'b1);
    set_frame_count(FRAME_COUNT_RESET);
  endtask

  task automatic test_small_pool();
    logic [FRAME_COUNT_W-1:0] sizes [4];
    int i, n;
    sizes = '{13'd32, 13'd64, 13'd33, 13'd96};
    for (i = 0; i < 4; i++) begin
      set_frame_count(sizes[i]);
      collect_held_frames();
      idle_enable = (i != 1);
      // run the pool dry, then reopen holes and refill them
      n = free_frames_in_scan() + 1 + $urandom_range(0, 1);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        alloc_fresh();
      end
      repeat (held_frames.size() / 2) free_held_frame();
      repeat ($urandom_range(4, 12)) alloc_fresh();
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_random_mix();
    int phase, k, r;
    for (phase = 0; phase < 4; phase++) begin
      case ($urandom_range(0, 3))
        0: set_frame_count(FRAME_COUNT_RESET);
        1: set_frame_count(13'h1fff);
        2: set_frame_count(FRAME_COUNT_W'($urandom_range(0, 8191)));
        default: set_frame_count(FRAME_COUNT_W'($urandom_range(1, 128) * MAP_WORD));
      endcase
      collect_held_frames();
      idle_enable = ($urandom_range(0, 9) < 7);
      for (k = 0; k < 60; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45)      alloc_fresh();
        else if (r < 75) free_held_frame();
        else if (r < 95) send_noise();
        else send_request(OP_FREE, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_pool_fill();
    int n;
    set_frame_count(13'd160);
    idle_enable = 1'b0;
    n = free_frames_in_scan() + 1;
    repeat (n) alloc_fresh();
    // holes are refilled lowest first
    idle_enable = 1'b1;
    collect_held_frames();
    repeat (40) free_held_frame();
    repeat (45) alloc_fresh();
    // top frame lies outside a scan of 127 words
    set_frame_count(13'd4064);
    send_request(OP_FREE, 12'hfff, 1'b0, 1'b0);
    send_request(OP_ALLOC, '0, 1'b0, 1'b1);
    set_frame_count(FRAME_COUNT_RESET);
    send_request(OP_ALLOC, '0, 1'b1, 1'b1);
  endtask

  initial begin
    for (int w = 0; w < MAP_DEPTH; w++) frame_map[w] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_alloc_basics();
    test_free_cases();
    test_frame_count_limits();
    test_small_pool();
    test_random_mix();
    test_pool_fill();

    wait_idle();
    repeat (140) @(posedge clk);
    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("** frame_bitmap_allocator_unit: PASSED **");
    end else begin
      $display("** frame_bitmap_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/fba_pkg.sv
rtl/fba_ram.sv
rtl/frame_bitmap_allocator_unit.sv
bench/frame_bitmap_allocator_unit_tb.sv
